@@ rtl/serial_channel_change_sequencer_top_macros.svh @@
// assertion macros for the channel change sequencer
`ifndef SERIAL_CHANNEL_CHANGE_SEQUENCER_TOP_MACROS_SVH
`define SERIAL_CHANNEL_CHANGE_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTH
`define SCC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
`define SCC_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define SCC_ASSERT_IMP(name, pre, post, msg)
`define SCC_ASSERT_NXT(name, pre, post, msg)
`endif

`endif

@@ rtl/scc_pkg.sv @@
// shared types and constants of the channel change sequencer
`default_nettype none

package scc_pkg;

  localparam int SCC_QUEUE_DEPTH = 2;
  localparam logic [2:0] POKE_LIMIT = 3'd5;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [1:0] CS_OLD     = 2'd0;
  localparam logic [1:0] CS_NEW     = 2'd1;
  localparam logic [1:0] CS_UNKNOWN = 2'd2;
  localparam logic [1:0] CS_INVALID = 2'd3;

  localparam logic [1:0] REG_FAST_MODE   = 2'd0;
  localparam logic [1:0] REG_SEND_ALL    = 2'd1;
  localparam logic [1:0] REG_DROP_TRAIL  = 2'd2;
  localparam logic [1:0] REG_COMMAND_SET = 2'd3;

  localparam logic [7:0] BYTE_HEADER   = 8'hFA;
  localparam logic [7:0] BYTE_DIRECT   = 8'hA6;
  localparam logic [7:0] BYTE_DIGIT    = 8'hA5;
  localparam logic [7:0] BYTE_DIR_OLD  = 8'h46;
  localparam logic [7:0] BYTE_KEY_BASE = 8'hE0;
  localparam logic [7:0] BYTE_ALT_TOP  = 8'hCF;
  localparam logic [7:0] BYTE_POKE     = 8'hFF;
  localparam logic [7:0] BYTE_TRAILER  = 8'h0D;
  localparam logic [7:0] BYTE_PAD      = 8'h00;

  localparam logic [7:0] RPL_ACCEPT = 8'hF0;
  localparam logic [7:0] RPL_FAIL   = 8'hF1;
  localparam logic [7:0] RPL_BUSY   = 8'hF2;
  localparam logic [7:0] RPL_DONE   = 8'hF4;
  localparam logic [7:0] RPL_ALT    = 8'hF5;
  localparam logic [7:0] RPL_IDLE   = 8'hFB;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIGIT,
    PH_DIRECT
  } scc_phase_t;

  typedef enum logic [1:0] {
    DIG_IDLE,
    DIG_QUOT,
    DIG_REM,
    DIG_SPLIT
  } scc_dig_t;

  typedef struct packed {
    logic       fast_mode;
    logic       send_all_at_once;
    logic       drop_trailer;
    logic       set_wr;
    logic [1:0] set_val;
  } scc_cfg_t;

  // one request worth of results: bytes first, then an optional completion
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [6:0][7:0] bytes;
    logic            done;
    logic            ok;
  } scc_job_t;

endpackage

`default_nettype wire

@@ rtl/serial_channel_change_sequencer_top.sv @@
// top level of the serial channel change sequencer
`default_nettype none

`include "serial_channel_change_sequencer_top_macros.svh"

// Each request (start, reply byte or reply timeout) is taken by the front end,
// which updates the sequence state and queues the bytes and completion it
// causes; the back end then hands out one result per cycle while out_ready
// allows, and further requests are taken into the job queue (QUEUE_DEPTH
// jobs) behind the job being handed out. A start request holds in_ready low
// while the channel number is split into decimal digits (DIG_QUOT, DIG_REM,
// DIG_SPLIT). Configuration registers sit at byte addresses 0, 4, 8 and 12;
// writing initial_command_set also reloads the live command set.
module serial_channel_change_sequencer_top #(
  parameter int QUEUE_DEPTH = scc_pkg::SCC_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] channel,
  input  wire logic [7:0]  reply_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             is_byte,
  output logic             success,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import scc_pkg::*;

  logic       fast_mode;
  logic       send_all_at_once;
  logic       drop_trailer;
  logic [1:0] initial_command_set;
  logic       cfg_wr;
  logic [1:0] set_val;
  scc_cfg_t   cfg;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_valid;
  scc_job_t   push_job;
  scc_job_t   head_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign set_val = (pwdata[1:0] == CS_INVALID) ? CS_UNKNOWN : pwdata[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_mode           <= 1'b0;
      send_all_at_once    <= 1'b0;
      drop_trailer        <= 1'b0;
      initial_command_set <= CS_UNKNOWN;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FAST_MODE:   fast_mode           <= pwdata[0];
        REG_SEND_ALL:    send_all_at_once    <= pwdata[0];
        REG_DROP_TRAIL:  drop_trailer        <= pwdata[0];
        REG_COMMAND_SET: initial_command_set <= set_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FAST_MODE:   prdata = 32'(fast_mode);
      REG_SEND_ALL:    prdata = 32'(send_all_at_once);
      REG_DROP_TRAIL:  prdata = 32'(drop_trailer);
      REG_COMMAND_SET: prdata = 32'(initial_command_set);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.fast_mode        = fast_mode;
    cfg.send_all_at_once = send_all_at_once;
    cfg.drop_trailer     = drop_trailer;
    cfg.set_wr           = cfg_wr && (paddr[3:2] == REG_COMMAND_SET);
    cfg.set_val          = set_val;
  end

  scc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .channel    (channel),
    .reply_byte (reply_byte),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (q_push),
    .job        (push_job)
  );

  scc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  scc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .is_byte    (is_byte),
    .success    (success),
    .last       (last)
  );

  `SCC_ASSERT_IMP(a_done_is_last, out_valid && !is_byte, last && tx_byte == 8'h00, "completion not last")
  `SCC_ASSERT_IMP(a_byte_no_success, out_valid && is_byte, !success, "byte result flags success")
  `SCC_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "job queue popped while empty")
  `SCC_ASSERT_NXT(a_start_stalls, in_valid && in_ready && operation == OP_START, !in_ready, "no stall after start")

endmodule

`default_nettype wire

@@ rtl/scc_front.sv @@
// front end: takes requests, keeps sequence state and builds result jobs
`default_nettype none

module scc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       operation,
  input  wire logic [15:0]      channel,
  input  wire logic [7:0]       reply_byte,
  input  wire scc_pkg::scc_cfg_t cfg,
  input  wire logic             q_full,
  output logic                  push,
  output scc_pkg::scc_job_t     job
);
  import scc_pkg::*;

  scc_phase_t  phase, phase_next;
  scc_dig_t    dig, dig_next;
  logic [1:0]  digit_index, digit_index_next;
  logic [2:0]  pokes_left, pokes_left_next;
  logic [15:0] channel_latch, channel_latch_next;
  logic [1:0]  command_set, command_set_next;
  logic        alternate_base, alternate_base_next;
  logic        base_confirmed, base_confirmed_next;

  logic [9:0]  quot;
  logic [6:0]  rem;
  logic [7:0]  hund;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [32:0] quot_prod;
  logic [14:0] tens_prod;
  logic [3:0]  tens_val;

  logic            accept;
  logic [1:0]      digit_inc;
  logic [7:0]      digit_val;
  logic [7:0]      key;
  logic [6:0][7:0] cmd;
  logic [2:0]      cmd_len;

  function automatic logic [6:0][7:0] direct_bytes(input logic [15:0] ch,
                                                   input logic [1:0]  cs);
    logic [6:0][7:0] b;
    b[0] = BYTE_HEADER;
    b[1] = (cs == CS_OLD) ? BYTE_DIR_OLD : BYTE_DIRECT;
    b[2] = ch[15:8];
    b[3] = ch[7:0];
    b[4] = BYTE_POKE;
    b[5] = BYTE_POKE;
    b[6] = BYTE_TRAILER;
    return b;
  endfunction

  assign in_ready = (dig == DIG_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // decimal split of the latched channel
  assign quot_prod = 33'(channel_latch) * 33'd83887;
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens_val  = tens_prod[14:11];

  always_ff @(posedge clk) begin
    case (dig)
      DIG_QUOT: quot <= quot_prod[32:23];
      DIG_REM: begin
        rem  <= 7'(channel_latch - 16'(16'(quot) * 16'd100));
        hund <= quot[7:0];
      end
      DIG_SPLIT: begin
        tens <= tens_val;
        ones <= 4'(rem - 7'(7'(tens_val) * 7'd10));
      end
      default: ;
    endcase
  end

  always_comb begin
    case (digit_index)
      2'd0:    digit_val = hund;
      2'd1:    digit_val = 8'(tens);
      default: digit_val = 8'(ones);
    endcase
    key = alternate_base ? 8'(BYTE_ALT_TOP - digit_val) : 8'(BYTE_KEY_BASE + digit_val);
  end

  assign cmd     = direct_bytes(operation == OP_START ? channel : channel_latch, command_set);
  assign cmd_len = (command_set == CS_OLD) ? 3'd4 : (cfg.drop_trailer ? 3'd6 : 3'd7);
  assign digit_inc = 2'(digit_index + 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      dig            <= DIG_IDLE;
      digit_index    <= '0;
      pokes_left     <= '0;
      channel_latch  <= '0;
      command_set    <= CS_UNKNOWN;
      alternate_base <= 1'b0;
      base_confirmed <= 1'b0;
    end else begin
      phase          <= phase_next;
      dig            <= dig_next;
      digit_index    <= digit_index_next;
      pokes_left     <= pokes_left_next;
      channel_latch  <= channel_latch_next;
      command_set    <= command_set_next;
      alternate_base <= alternate_base_next;
      base_confirmed <= base_confirmed_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    digit_index_next    = digit_index;
    pokes_left_next     = pokes_left;
    channel_latch_next  = channel_latch;
    command_set_next    = command_set;
    alternate_base_next = alternate_base;
    base_confirmed_next = base_confirmed;
    job                 = '0;

    case (dig)
      DIG_IDLE:  dig_next = (accept && operation == OP_START) ? DIG_QUOT : DIG_IDLE;
      DIG_QUOT:  dig_next = DIG_REM;
      DIG_REM:   dig_next = DIG_SPLIT;
      default:   dig_next = DIG_IDLE;
    endcase

    if (cfg.set_wr) begin
      command_set_next = cfg.set_val;
    end

    if (accept) begin
      case (operation)
        OP_START: begin
          channel_latch_next = channel;
          if (!cfg.fast_mode && command_set != CS_OLD) begin
            phase_next       = PH_DIGIT;
            digit_index_next = '0;
            job.nbytes       = 3'd2;
            job.bytes[0]     = BYTE_HEADER;
            job.bytes[1]     = BYTE_DIGIT;
          end else begin
            phase_next      = PH_DIRECT;
            pokes_left_next = POKE_LIMIT;
            job.bytes       = cmd;
            job.nbytes      = cfg.send_all_at_once ? cmd_len : 3'd2;
          end
        end
        OP_REPLY: begin
          if (phase == PH_DIGIT) begin
            case (reply_byte)
              RPL_ACCEPT: begin
                job.nbytes   = 3'd3;
                job.bytes[0] = BYTE_PAD;
                job.bytes[1] = BYTE_PAD;
                job.bytes[2] = key;
              end
              RPL_BUSY, RPL_IDLE: ;
              RPL_DONE, RPL_ALT: begin
                if (reply_byte == RPL_ALT && !alternate_base && !base_confirmed) begin
                  alternate_base_next = 1'b1;
                  job.nbytes          = 3'd2;
                  job.bytes[0]        = BYTE_HEADER;
                  job.bytes[1]        = BYTE_DIGIT;
                end else begin
                  if (reply_byte == RPL_DONE) begin
                    if (command_set == CS_UNKNOWN) begin
                      command_set_next = CS_OLD;
                    end
                    base_confirmed_next = 1'b1;
                  end
                  digit_index_next = digit_inc;
                  if (digit_inc == 2'd3) begin
                    job.done   = 1'b1;
                    job.ok     = 1'b1;
                    phase_next = PH_IDLE;
                  end else begin
                    job.nbytes   = 3'd2;
                    job.bytes[0] = BYTE_HEADER;
                    job.bytes[1] = BYTE_DIGIT;
                  end
                end
              end
              default: begin
                job.done   = 1'b1;
                phase_next = PH_IDLE;
              end
            endcase
          end else if (phase == PH_DIRECT) begin
            case (reply_byte)
              RPL_ACCEPT: begin
                if (!cfg.send_all_at_once) begin
                  job.bytes  = cmd >> 16;
                  job.nbytes = 3'(cmd_len - 3'd2);
                end
              end
              RPL_BUSY, RPL_IDLE: ;
              RPL_DONE: begin
                job.done   = 1'b1;
                job.ok     = 1'b1;
                phase_next = PH_IDLE;
              end
              default: begin
                job.done   = 1'b1;
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
        OP_TIMEOUT: begin
          if (phase == PH_DIGIT) begin
            if (command_set == CS_UNKNOWN) begin
              command_set_next = CS_NEW;
              job.nbytes       = 3'd2;
              job.bytes[0]     = BYTE_HEADER;
              job.bytes[1]     = BYTE_DIGIT;
            end else begin
              job.done   = 1'b1;
              phase_next = PH_IDLE;
            end
          end else if (phase == PH_DIRECT) begin
            if (pokes_left != 3'd0) begin
              pokes_left_next = 3'(pokes_left - 3'd1);
              job.nbytes      = 3'd1;
              job.bytes[0]    = BYTE_POKE;
            end else begin
              job.done   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push = accept && ((job.nbytes != 3'd0) || job.done);

endmodule

`default_nettype wire

@@ rtl/scc_queue.sv @@
// short job queue between the front and back ends
`default_nettype none

module scc_queue #(
  parameter int DEPTH = scc_pkg::SCC_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire scc_pkg::scc_job_t push_job,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output scc_pkg::scc_job_t      head_job
);
  import scc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  scc_job_t          entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CntW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/scc_back.sv @@
// back end: unrolls each job into results behind an output register
`default_nettype none

module scc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire scc_pkg::scc_job_t head_job,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             tx_byte,
  output logic                   is_byte,
  output logic                   success,
  output logic                   last
);
  import scc_pkg::*;

  logic [2:0] idx;
  logic       advance;
  logic       take;
  logic       res_is_byte;
  logic       res_last;
  logic [7:0] res_byte;

  assign advance = !out_valid || out_ready;
  assign take    = advance && head_valid;

  always_comb begin
    res_is_byte = (idx < head_job.nbytes);
    res_byte    = res_is_byte ? head_job.bytes[idx] : 8'h00;
    res_last    = res_is_byte ? ((3'(idx + 3'd1) == head_job.nbytes) && !head_job.done)
                              : 1'b1;
  end

  assign pop = take && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= head_valid;
      end
      if (pop) begin
        idx <= '0;
      end else if (take) begin
        idx <= 3'(idx + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tx_byte <= res_byte;
      is_byte <= res_is_byte;
      success <= !res_is_byte && head_job.ok;
      last    <= res_last;
    end
  end

endmodule

`default_nettype wire

@@ dv/serial_channel_change_sequencer_top_test.sv @@
// testbench for the channel change sequencer: directed table, then state-driven random requests
`timescale 1ns / 1ps

module serial_channel_change_sequencer_top_test;
  import scc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] K_BYTE = 2'b10;
  localparam logic [9:0] F_NIL = '0;
  localparam logic [9:0] F_HDR = {K_BYTE, BYTE_HEADER};
  localparam logic [9:0] F_DIG = {K_BYTE, BYTE_DIGIT};
  localparam logic [9:0] F_OLD = {K_BYTE, BYTE_DIR_OLD};
  localparam logic [9:0] F_PAD = {K_BYTE, BYTE_PAD};
  localparam logic [9:0] F_KEY = {K_BYTE, BYTE_KEY_BASE};
  localparam logic [9:0] END_OK = {2'b01, BYTE_PAD};
  localparam logic [9:0] END_BAD = {2'b00, BYTE_PAD};
  localparam int PRED = -1;
  localparam int SETTLE = 12;
  localparam int PLAN_ROWS = 33;

  typedef struct packed {
    logic [7:0] tx;
    logic       isb;
    logic       ok;
    logic       lst;
  } res_t;

  typedef struct {
    bit         cfg;
    logic [1:0] code;
    logic [15:0] chan;
    logic [7:0] val;
    int         nfix;
    logic [9:0] f0;
    logic [9:0] f1;
    logic [9:0] f2;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic [15:0] channel = '0;
  logic [7:0] reply_byte = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [7:0] tx_byte;
  logic is_byte;
  logic success;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  logic cfg_fast = 1'b0;
  logic cfg_all = 1'b0;
  logic cfg_drop = 1'b0;
  logic [1:0] cur_set = CS_UNKNOWN;
  scc_phase_t seq_ph = PH_IDLE;
  logic [1:0] dig_idx = '0;
  logic [2:0] pokes = '0;
  logic [15:0] chan_q = '0;
  logic alt_base = 1'b0;
  logic base_conf = 1'b0;

  res_t fresh[$];
  res_t due_q[$];
  int mismatches = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int gap_pct = 0;
  bit calm = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{0, OP_START, 16'd0, 8'h00, 2, F_HDR, F_DIG, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ACCEPT, 3, F_PAD, F_PAD, F_KEY},
    '{0, OP_REPLY, 16'd0, RPL_ALT, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ACCEPT, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_DONE, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ALT, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_DONE, 1, END_OK, F_NIL, F_NIL},
    '{0, OP_START, 16'hFFFF, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ACCEPT, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_START, 16'd999, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, 8'h00, 1, END_BAD, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ACCEPT, 0, F_NIL, F_NIL, F_NIL},
    '{0, OP_NONE, 16'hFFFF, 8'hFF, 0, F_NIL, F_NIL, F_NIL},
    '{1, REG_COMMAND_SET, 16'd0, 8'(CS_INVALID), 0, F_NIL, F_NIL, F_NIL},
    '{1, REG_FAST_MODE, 16'd0, 8'd1, 0, F_NIL, F_NIL, F_NIL},
    '{1, REG_SEND_ALL, 16'd0, 8'd1, 0, F_NIL, F_NIL, F_NIL},
    '{1, REG_DROP_TRAIL, 16'd0, 8'd1, 0, F_NIL, F_NIL, F_NIL},
    '{0, OP_START, 16'h8001, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ACCEPT, 0, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_FAIL, 1, END_BAD, F_NIL, F_NIL},
    '{1, REG_COMMAND_SET, 16'd0, 8'(CS_OLD), 0, F_NIL, F_NIL, F_NIL},
    '{1, REG_SEND_ALL, 16'd0, 8'd0, 0, F_NIL, F_NIL, F_NIL},
    '{1, REG_DROP_TRAIL, 16'd0, 8'd0, 0, F_NIL, F_NIL, F_NIL},
    '{0, OP_START, 16'h1234, 8'h00, 2, F_HDR, F_OLD, F_NIL},
    '{0, OP_REPLY, 16'd0, RPL_ACCEPT, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, PRED, F_NIL, F_NIL, F_NIL},
    '{0, OP_TIMEOUT, 16'd0, 8'h00, 1, END_BAD, F_NIL, F_NIL}
  };

  serial_channel_change_sequencer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .channel    (channel),
    .reply_byte (reply_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .is_byte    (is_byte),
    .success    (success),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk = ~clk;

  function void put(logic [7:0] b, logic isb, logic ok);
    res_t r;
    r = '{tx: b, isb: isb, ok: ok, lst: 1'b0};
    if (fresh.size() < 7) fresh.push_back(r);
  endfunction

  function void put_byte(logic [7:0] b);
    put(b, 1'b1, 1'b0);
  endfunction

  function void complete(logic ok);
    put(BYTE_PAD, 1'b0, ok);
    seq_ph = PH_IDLE;
  endfunction

  function logic [7:0] key_of();
    logic [15:0] d;
    case (dig_idx)
      2'd0: d = chan_q / 16'd100;
      2'd1: d = (chan_q % 16'd100) / 16'd10;
      default: d = chan_q % 16'd10;
    endcase
    return alt_base ? BYTE_ALT_TOP - d[7:0] : BYTE_KEY_BASE + d[7:0];
  endfunction

  function void header();
    put_byte(BYTE_HEADER);
    put_byte(BYTE_DIGIT);
  endfunction

  function void next_digit();
    dig_idx = dig_idx + 2'd1;
    if (dig_idx == 2'd3) complete(1'b1);
    else header();
  endfunction

  function void send_direct(bit tail_only);
    logic [7:0] cmd [7];
    int n;
    int lo;
    int hi;
    int i;
    cmd[0] = BYTE_HEADER;
    cmd[1] = (cur_set == CS_OLD) ? BYTE_DIR_OLD : BYTE_DIRECT;
    cmd[2] = chan_q[15:8];
    cmd[3] = chan_q[7:0];
    cmd[4] = BYTE_POKE;
    cmd[5] = BYTE_POKE;
    cmd[6] = BYTE_TRAILER;
    n = (cur_set == CS_OLD) ? 4 : (cfg_drop ? 6 : 7);
    lo = tail_only ? 2 : 0;
    hi = (tail_only || cfg_all) ? n : 2;
    for (i = lo; i < hi; i++) put_byte(cmd[i]);
  endfunction

  function void digit_reply(logic [7:0] rb);
    case (rb)
      RPL_ACCEPT: begin
        put_byte(BYTE_PAD);
        put_byte(BYTE_PAD);
        put_byte(key_of());
      end
      RPL_BUSY, RPL_IDLE: ;
      RPL_DONE: begin
        if (cur_set == CS_UNKNOWN) cur_set = CS_OLD;
        base_conf = 1'b1;
        next_digit();
      end
      RPL_ALT: begin
        if (!alt_base && !base_conf) begin
          alt_base = 1'b1;
          header();
        end else begin
          next_digit();
        end
      end
      default: complete(1'b0);
    endcase
  endfunction

  function void direct_reply(logic [7:0] rb);
    case (rb)
      RPL_ACCEPT: if (!cfg_all) send_direct(1'b1);
      RPL_BUSY, RPL_IDLE: ;
      RPL_DONE: complete(1'b1);
      default: complete(1'b0);
    endcase
  endfunction

  function void predict(logic [1:0] op, logic [15:0] ch, logic [7:0] rb);
    fresh.delete();
    case (op)
      OP_START: begin
        chan_q = ch;
        if (!cfg_fast && cur_set != CS_OLD) begin
          seq_ph = PH_DIGIT;
          dig_idx = '0;
          header();
        end else begin
          seq_ph = PH_DIRECT;
          pokes = POKE_LIMIT;
          send_direct(1'b0);
        end
      end
      OP_REPLY: begin
        if (seq_ph == PH_DIGIT) digit_reply(rb);
        else if (seq_ph == PH_DIRECT) direct_reply(rb);
      end
      OP_TIMEOUT: begin
        if (seq_ph == PH_DIGIT) begin
          if (cur_set == CS_UNKNOWN) begin
            cur_set = CS_NEW;
            header();
          end else begin
            complete(1'b0);
          end
        end else if (seq_ph == PH_DIRECT) begin
          if (pokes != 3'd0) begin
            pokes = pokes - 3'd1;
            put_byte(BYTE_POKE);
          end else begin
            complete(1'b0);
          end
        end
      end
      default: ;
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].lst = 1'b1;
  endfunction

  function void cfg_apply(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_FAST_MODE: cfg_fast = val[0];
      REG_SEND_ALL: cfg_all = val[0];
      REG_DROP_TRAIL: cfg_drop = val[0];
      default: cur_set = (val[1:0] == CS_INVALID) ? CS_UNKNOWN : val[1:0];
    endcase
  endfunction

  task automatic issue(logic [1:0] op, logic [15:0] ch, logic [7:0] rb, int nfix,
                       logic [9:0] f0, logic [9:0] f1, logic [9:0] f2);
    logic [9:0] fx [3];
    res_t r;
    int i;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    predict(op, ch, rb);
    if (nfix < 0) begin
      for (i = 0; i < fresh.size(); i++) due_q.push_back(fresh[i]);
    end else begin
      fx[0] = f0;
      fx[1] = f1;
      fx[2] = f2;
      for (i = 0; i < nfix; i++) begin
        r = '{tx: fx[i][7:0], isb: fx[i][9], ok: fx[i][8], lst: (i == nfix - 1)};
        due_q.push_back(r);
      end
    end
    in_valid <= 1'b1;
    operation <= op;
    channel <= ch;
    reply_byte <= rb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_apply(idx, val);
    @(posedge clk);
  endtask

  task automatic write_noisy(logic [1:0] idx, logic [1:0] v);
    logic [31:0] w;
    w = $urandom;
    w[1:0] = v;
    write_reg(idx, w);
  endtask

  task automatic note_bad(string what, res_t want, res_t got);
    if (mismatches < 10)
      $display({"%s: expected tx_byte=%02h is_byte=%0b success=%0b last=%0b,",
                " got tx_byte=%02h is_byte=%0b success=%0b last=%0b"},
               what, want.tx, want.isb, want.ok, want.lst,
               got.tx, got.isb, got.ok, got.lst);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{tx: tx_byte, isb: is_byte, ok: success, lst: last};
      if (due_q.size() == 0) begin
        note_bad("unexpected result", '0, got);
      end else begin
        want = due_q.pop_front();
        if (got !== want) note_bad("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || calm || stall_pct == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(4, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int row;
    int phase_no;
    int n;
    int r;
    logic [1:0] op;
    logic [15:0] ch;
    logic [7:0] rb;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stall_pct = 30;
    gap_pct = 30;
    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].cfg) begin
        settle();
        write_reg(plan[row].code, {24'd0, plan[row].val});
      end else begin
        issue(plan[row].code, plan[row].chan, plan[row].val, plan[row].nfix,
              plan[row].f0, plan[row].f1, plan[row].f2);
      end
    end

    for (phase_no = 0; phase_no < 8; phase_no++) begin
      settle();
      case (phase_no)
        0: begin
          write_noisy(REG_FAST_MODE, 2'd0);
          write_noisy(REG_SEND_ALL, 2'd0);
          write_noisy(REG_DROP_TRAIL, 2'd0);
          write_noisy(REG_COMMAND_SET, CS_OLD);
        end
        1: begin
          write_noisy(REG_FAST_MODE, 2'd1);
          write_noisy(REG_SEND_ALL, 2'd1);
          write_noisy(REG_DROP_TRAIL, 2'd1);
          write_noisy(REG_COMMAND_SET, CS_UNKNOWN);
        end
        default: begin
          write_noisy(REG_FAST_MODE, 2'($urandom_range(3)));
          write_noisy(REG_SEND_ALL, 2'($urandom_range(3)));
          write_noisy(REG_DROP_TRAIL, 2'($urandom_range(3)));
          write_noisy(REG_COMMAND_SET, 2'($urandom_range(3)));
        end
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 50;
      endcase
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      calm = (phase_no == 7);
      n = 0;
      while (n < 29) begin
        r = $urandom_range(99);
        op = OP_REPLY;
        rb = 8'($urandom);
        ch = 16'($urandom);
        case (seq_ph)
          PH_IDLE: begin
            if (r < 85) op = OP_START;
            else if (r < 92) op = OP_TIMEOUT;
            else if (r < 96) op = OP_NONE;
          end
          PH_DIGIT: begin
            if (r < 35) rb = RPL_ACCEPT;
            else if (r < 55) rb = RPL_DONE;
            else if (r < 70) rb = RPL_ALT;
            else if (r < 73) rb = RPL_BUSY;
            else if (r < 76) rb = RPL_IDLE;
            else if (r < 84) op = OP_TIMEOUT;
            else if (r < 90) ;
            else if (r < 94) rb = RPL_FAIL;
            else if (r < 96) op = OP_NONE;
            else op = OP_START;
          end
          default: begin
            if (r < 25) rb = RPL_ACCEPT;
            else if (r < 58) op = OP_TIMEOUT;
            else if (r < 70) rb = RPL_DONE;
            else if (r < 74) rb = RPL_BUSY;
            else if (r < 78) rb = RPL_IDLE;
            else if (r < 84) rb = RPL_FAIL;
            else if (r < 90) ;
            else if (r < 94) op = OP_NONE;
            else op = OP_START;
          end
        endcase
        if (op == OP_START && $urandom_range(4) != 0) ch = 16'($urandom_range(999));
        if (op == OP_START || (op != OP_NONE && seq_ph != PH_IDLE)) n++;
        issue(op, ch, rb, PRED, F_NIL, F_NIL, F_NIL);
      end
    end

    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_front.sv
rtl/scc_queue.sv
rtl/scc_back.sv
rtl/serial_channel_change_sequencer_top.sv
dv/serial_channel_change_sequencer_top_test.sv
